// File: rtl/opd_pkg.sv
// Shared types and constants for the obstacle proximity detector.
// No dependencies; every rtl file imports this package.
`timescale 1ns / 1ps

package opd_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_MIN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_MAX     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORWARD_MIN    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_RADIUS_SQ = 2'd3;

    // Register reset values (Q5.10 m and Q10.20 m^2)
    localparam logic signed [15:0] HEIGHT_MIN_RST     = 16'sd77;
    localparam logic signed [15:0] HEIGHT_MAX_RST     = 16'sd512;
    localparam logic signed [15:0] FORWARD_MIN_RST    = 16'sd256;
    localparam logic [31:0]        NEAR_RADIUS_SQ_RST = 32'd946340;

    // Kept-point counter saturates at the smaller of COUNT_MAX and the field range
    localparam int unsigned COUNT_MAX   = 65535;
    localparam logic [15:0] COUNT_LIMIT = 16'((COUNT_MAX > 65535) ? 65535 : COUNT_MAX);

    localparam logic [31:0] DIST_NONE = '1;

    // Word widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 72;

    typedef struct packed {
        logic signed [15:0] height_min;
        logic signed [15:0] height_max;
        logic signed [15:0] forward_min;
        logic [31:0]        near_radius_sq;
    } cfg_regs_t;

    // Word after the squaring stage
    typedef struct packed {
        logic               valid;
        logic               last;
        logic signed [15:0] z;
        logic               range_ok;
        logic [31:0]        sq_x;
        logic [31:0]        sq_y;
    } sq_stage_t;

    // Word after the distance gate
    typedef struct packed {
        logic               valid;
        logic               last;
        logic signed [15:0] z;
        logic               kept;
        logic [31:0]        dist_sq;
    } gate_stage_t;

endpackage

// File: rtl/opd_square.sv
// Input register, box tests on height and forward coordinate, and the two squarers.
// Depends on opd_pkg.
`timescale 1ns / 1ps

module opd_square
    import opd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  logic [IN_DATA_W-1:0] in_data,
    input  logic                 in_last,
    input  cfg_regs_t            cfg,
    output sq_stage_t            sq_out
);

    logic               valid_reg;
    logic               last_reg;
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic signed [15:0] z_reg;

    sq_stage_t          sq_reg;
    sq_stage_t          sq_next;
    logic signed [31:0] prod_x;
    logic signed [31:0] prod_y;

    // Capture the incoming word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg    <= in_data[15:0];
            y_reg    <= in_data[31:16];
            z_reg    <= in_data[47:32];
            last_reg <= in_last;
        end
    end

    // Square both planar coordinates; (-2^15)^2 still fits in 31 bits
    assign prod_x = x_reg * x_reg;
    assign prod_y = y_reg * y_reg;

    always_comb
    begin
        sq_next.valid    = valid_reg;
        sq_next.last     = last_reg;
        sq_next.z        = z_reg;
        sq_next.range_ok = (z_reg > cfg.height_min) && (z_reg < cfg.height_max)
                           && (x_reg > cfg.forward_min);
        sq_next.sq_x     = 32'(unsigned'(prod_x));
        sq_next.sq_y     = 32'(unsigned'(prod_y));
    end

    // Hold the squares for the gate stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg <= '0;
        end
        else if (advance)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sq_out = sq_reg;

endmodule

// File: rtl/opd_gate.sv
// Planar distance sum and radius compare; decides whether a point is kept.
// Depends on opd_pkg.
`timescale 1ns / 1ps

module opd_gate
    import opd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [31:0] near_radius_sq,
    input  sq_stage_t   sq_in,
    output gate_stage_t gate_out
);

    gate_stage_t gate_reg;
    logic [31:0] dist_sq;

    // Sum is at most 2^31, so 32 bits hold it exactly
    assign dist_sq = sq_in.sq_x + sq_in.sq_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg <= '0;
        end
        else if (advance)
        begin
            gate_reg.valid   <= sq_in.valid;
            gate_reg.last    <= sq_in.last;
            gate_reg.z       <= sq_in.z;
            gate_reg.kept    <= sq_in.range_ok && (dist_sq < near_radius_sq);
            gate_reg.dist_sq <= dist_sq;
        end
    end

    assign gate_out = gate_reg;

endmodule

// File: rtl/opd_track.sv
// Per-cloud running minimum, kept counter and the output word register.
// Depends on opd_pkg.
`timescale 1ns / 1ps

module opd_track
    import opd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  gate_stage_t           gate_in,
    output logic                  out_valid,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_last
);

    logic               best_valid_dummy;
    logic [31:0]        best_dist_reg;
    logic [31:0]        best_dist_next;
    logic signed [15:0] best_height_reg;
    logic signed [15:0] best_height_next;
    logic               near_seen_reg;
    logic               near_seen_next;
    logic [15:0]        kept_total_reg;
    logic [15:0]        kept_total_next;
    logic               closer;

    logic               out_valid_reg;
    logic               out_last_reg;
    logic               kept_out_reg;
    logic               prox_out_reg;
    logic [31:0]        dist_out_reg;
    logic signed [15:0] height_out_reg;
    logic [15:0]        count_out_reg;

    // Fold this point into the cloud summary; ties keep the earlier point
    assign closer           = gate_in.kept && (gate_in.dist_sq < best_dist_reg);
    assign best_dist_next   = closer ? gate_in.dist_sq : best_dist_reg;
    assign best_height_next = closer ? gate_in.z : best_height_reg;
    assign near_seen_next   = near_seen_reg | gate_in.kept;
    assign kept_total_next  = (gate_in.kept && (kept_total_reg < COUNT_LIMIT))
                              ? kept_total_reg + 16'd1 : kept_total_reg;
    assign best_valid_dummy = gate_in.valid && advance;

    // Update summary state; clear it after the last point of a cloud
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg   <= DIST_NONE;
            best_height_reg <= '0;
            near_seen_reg   <= 1'b0;
            kept_total_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= gate_in.valid;
            if (best_valid_dummy)
            begin
                if (gate_in.last)
                begin
                    best_dist_reg   <= DIST_NONE;
                    best_height_reg <= '0;
                    near_seen_reg   <= 1'b0;
                    kept_total_reg  <= '0;
                end
                else
                begin
                    best_dist_reg   <= best_dist_next;
                    best_height_reg <= best_height_next;
                    near_seen_reg   <= near_seen_next;
                    kept_total_reg  <= kept_total_next;
                end
            end
        end
    end

    // Output word: summary fields only on the last point, zero otherwise
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_last_reg <= gate_in.last;
            kept_out_reg <= gate_in.kept;
            if (gate_in.last)
            begin
                prox_out_reg   <= near_seen_next;
                dist_out_reg   <= best_dist_next;
                height_out_reg <= best_height_next;
                count_out_reg  <= kept_total_next;
            end
            else
            begin
                prox_out_reg   <= 1'b0;
                dist_out_reg   <= '0;
                height_out_reg <= '0;
                count_out_reg  <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {6'd0, count_out_reg, height_out_reg, dist_out_reg,
                        prox_out_reg, kept_out_reg};

endmodule

// File: rtl/obstacle_proximity_detector.sv
// Top level of the obstacle proximity detector: config registers, stall control, pipeline.
// Depends on opd_pkg, opd_square, opd_gate, opd_track.
//
//  channel | signals                          | word contents (low bit up)
//  --------+----------------------------------+-----------------------------------------
//  s       | s_tvalid s_tready s_tdata s_tlast| point_x, point_y, point_z; tlast=last_point
//  m       | m_tvalid m_tready m_tdata m_tlast| point_kept, proximity, nearest_dist_sq,
//          |                                  | nearest_height, kept_count; tlast=cloud_done
//  cfg     | cfg_valid cfg_ready cfg_index    | cfg_data[15:0] or [31:0] per register
//
// One word per cycle sustained while the output is not stalled; each word passes through
// the input register, squarers, distance gate and output register in turn.
// The two 16x16 squarers and the 32-bit add-and-compare set the stage lengths.
// Reset clears the pipeline, the cloud summary and loads register defaults.
// A stalled output word freezes every stage; s_tready drops in the same cycle.
`timescale 1ns / 1ps

module obstacle_proximity_detector
    import opd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // point_x, point_y, point_z
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // point_kept, proximity, nearest_dist_sq,
                                              // nearest_height, kept_count, zero pad
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    cfg_regs_t   cfg_reg;
    logic        advance;
    sq_stage_t   sq_stage;
    gate_stage_t gate_stage;

    // Whole pipeline moves when the output slot is free or being taken
    assign advance   = !m_tvalid || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.height_min     <= HEIGHT_MIN_RST;
            cfg_reg.height_max     <= HEIGHT_MAX_RST;
            cfg_reg.forward_min    <= FORWARD_MIN_RST;
            cfg_reg.near_radius_sq <= NEAR_RADIUS_SQ_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEIGHT_MIN:     cfg_reg.height_min     <= cfg_data[15:0];
                CFG_HEIGHT_MAX:     cfg_reg.height_max     <= cfg_data[15:0];
                CFG_FORWARD_MIN:    cfg_reg.forward_min    <= cfg_data[15:0];
                CFG_NEAR_RADIUS_SQ: cfg_reg.near_radius_sq <= cfg_data;
                default:            ;
            endcase
        end
    end

    opd_square u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .in_last  (s_tlast),
        .cfg      (cfg_reg),
        .sq_out   (sq_stage)
    );

    opd_gate u_gate (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .near_radius_sq (cfg_reg.near_radius_sq),
        .sq_in          (sq_stage),
        .gate_out       (gate_stage)
    );

    opd_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .gate_in   (gate_stage),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    // A stalled output word blocks intake
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    // Summary fields stay zero except on the last point of a cloud
    a_summary_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[OUT_DATA_W-1:1] == '0))
        else $error("summary fields set on a non-final point");

    // A kept final point must show up in the summary
    a_kept_implies_proximity: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && m_tdata[0]) |-> (m_tdata[1] && (m_tdata[65:50] != '0)))
        else $error("kept final point missing from summary");

    // Empty cloud reports no distance, no height and no count
    a_empty_cloud: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && !m_tdata[1]) |->
        ((m_tdata[33:2] == DIST_NONE) && (m_tdata[65:34] == '0)))
        else $error("empty cloud summary not in its cleared form");

endmodule
